### rtl/fuqp_pkg.sv
// Shared types, codes and helpers for the form-urlencoded query parser.
`timescale 1ns / 1ps

package fuqp_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int PAIR_CNT_W     = 16;
  localparam int FIFO_DEPTH     = 4;
  localparam int MAX_RES        = 3;

  // result kinds
  localparam logic [2:0] KIND_KEY  = 3'd0;
  localparam logic [2:0] KIND_VAL  = 3'd1;
  localparam logic [2:0] KIND_PAIR = 3'd2;
  localparam logic [2:0] KIND_END  = 3'd3;
  localparam logic [2:0] KIND_ERR  = 3'd4;

  // characters with meaning
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [2:0]            kind;
    logic [7:0]            data;
    logic                  has_value;
    logic [PAIR_CNT_W-1:0] pair_count;
    logic                  error_seen;
    logic                  last_result;
  } result_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

endpackage

### rtl/fuqp_if.sv
// Valid/ready channel interfaces for the parser's input bytes and results.
`timescale 1ns / 1ps

interface fuqp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       is_last;

  modport source (output valid, output byte_in, output is_last, input ready);
  modport sink   (input valid, input byte_in, input is_last, output ready);
endinterface

interface fuqp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  data;
  logic        has_value;
  logic [15:0] pair_count;
  logic        error_seen;
  logic        last_result;

  modport source (output valid, output kind, output data, output has_value,
                  output pair_count, output error_seen, output last_result,
                  input ready);
  modport sink   (input valid, input kind, input data, input has_value,
                  input pair_count, input error_seen, input last_result,
                  output ready);
endinterface

### rtl/form_urlencoded_query_parser.sv
// Top level: streaming form-urlencoded query string parser.
//
// Usage: query bytes enter on in_ch, one per beat, with is_last on the final
// byte of each string. Results leave on out_ch: key bytes, decoded value
// bytes, pair ends, errors and one string end per string; last_result marks
// the final result caused by an input beat.
// An accepted byte's results enter the result queue behind any results
// already queued. Throughput: one byte per cycle while each byte yields at
// most one result and out_ch is not stalled. A byte yields up to three
// results (data, pair end, string end); results drain one per cycle while
// out_ch is ready, through a four-entry result queue, and in_ch.ready is
// high while the queue holds at most one entry, so extra results stall input.
// Reset (rst_n low, synchronous) empties the queue and returns the parser to
// the start of a new string. When the receiver stalls out_ch, the queue
// fills and in_ch.ready drops; nothing is lost or reordered.
`timescale 1ns / 1ps

module form_urlencoded_query_parser #(
  parameter int COUNT_BITS = fuqp_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  fuqp_in_if.sink     in_ch,
  fuqp_out_if.source  out_ch
);

  localparam int PTR_BITS = $clog2(fuqp_pkg::FIFO_DEPTH);
  localparam int CNT_BITS = $clog2(fuqp_pkg::FIFO_DEPTH + 1);
  localparam int SAT_W    = (COUNT_BITS > fuqp_pkg::PAIR_CNT_W) ?
                            COUNT_BITS : fuqp_pkg::PAIR_CNT_W;

  typedef enum logic [2:0] {
    PH_KEY  = 3'd0,
    PH_VAL  = 3'd1,
    PH_HEX1 = 3'd2,
    PH_HEX2 = 3'd3,
    PH_DROP = 3'd4
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic                  start_r, start_nxt;
  logic                  seg_r, seg_nxt;
  logic                  eq_r, eq_nxt;
  logic [3:0]            hn_r, hn_nxt;
  logic [COUNT_BITS-1:0] pd_r, pd_nxt;
  logic                  err_r, err_nxt;

  fuqp_pkg::result_t     fifo_r [fuqp_pkg::FIFO_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;

  fuqp_pkg::result_t     res [fuqp_pkg::MAX_RES];
  logic [1:0]            n_res;
  logic                  in_fire, out_fire;

  function automatic logic [fuqp_pkg::PAIR_CNT_W-1:0] sat_count(
    input logic [COUNT_BITS-1:0] v
  );
    logic [SAT_W-1:0] ext;
    ext = SAT_W'(v);
    if (ext > SAT_W'({fuqp_pkg::PAIR_CNT_W{1'b1}}))
      return {fuqp_pkg::PAIR_CNT_W{1'b1}};
    return ext[fuqp_pkg::PAIR_CNT_W-1:0];
  endfunction

  function automatic fuqp_pkg::result_t mk_res(
    input logic [2:0]            kind,
    input logic [7:0]            data,
    input logic                  hv,
    input logic [COUNT_BITS-1:0] pd,
    input logic                  err
  );
    fuqp_pkg::result_t r;
    r.kind        = kind;
    r.data        = data;
    r.has_value   = hv;
    r.pair_count  = sat_count(pd);
    r.error_seen  = err;
    r.last_result = 1'b0;
    return r;
  endfunction

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (cnt_r <= CNT_BITS'(1));

  // per-byte parse step: state update and up to three results
  always_comb begin
    logic [7:0] c;
    logic [4:0] hx;
    c         = in_ch.byte_in;
    hx        = fuqp_pkg::hex_decode(c);
    phase_nxt = phase_r;
    start_nxt = 1'b0;
    seg_nxt   = seg_r;
    eq_nxt    = eq_r;
    hn_nxt    = hn_r;
    pd_nxt    = pd_r;
    err_nxt   = err_r;
    n_res     = 2'd0;
    for (int i = 0; i < fuqp_pkg::MAX_RES; i++) res[i] = '0;

    if (start_r && c == fuqp_pkg::CH_QUEST) begin
      // leading '?' dropped
    end else if (phase_r == PH_DROP) begin
    end else if (phase_r == PH_HEX1 || phase_r == PH_HEX2) begin
      if (!hx[4]) begin
        err_nxt   = 1'b1;
        phase_nxt = PH_DROP;
        seg_nxt   = 1'b0;
        eq_nxt    = 1'b0;
        res[0]    = mk_res(fuqp_pkg::KIND_ERR, 8'd0, 1'b0, pd_nxt, 1'b1);
        n_res     = 2'd1;
      end else if (phase_r == PH_HEX1) begin
        hn_nxt    = hx[3:0];
        phase_nxt = PH_HEX2;
      end else begin
        res[0]    = mk_res(fuqp_pkg::KIND_VAL, {hn_r, hx[3:0]}, 1'b0, pd_nxt, err_nxt);
        n_res     = 2'd1;
        phase_nxt = PH_VAL;
      end
    end else if (c == fuqp_pkg::CH_AMP) begin
      if (seg_r) begin
        if (!(&pd_r)) pd_nxt = pd_r + COUNT_BITS'(1);
        res[0]  = mk_res(fuqp_pkg::KIND_PAIR, 8'd0, eq_r, pd_nxt, err_nxt);
        n_res   = 2'd1;
        seg_nxt = 1'b0;
        eq_nxt  = 1'b0;
      end
      phase_nxt = PH_KEY;
    end else if (phase_r == PH_VAL) begin
      if (c == fuqp_pkg::CH_PCT) begin
        phase_nxt = PH_HEX1;
      end else begin
        res[0] = mk_res(fuqp_pkg::KIND_VAL,
                        (c == fuqp_pkg::CH_PLUS) ? fuqp_pkg::CH_SPACE : c,
                        1'b0, pd_nxt, err_nxt);
        n_res  = 2'd1;
      end
    end else begin
      phase_nxt = PH_KEY;
      seg_nxt   = 1'b1;
      if (c == fuqp_pkg::CH_EQ) begin
        eq_nxt    = 1'b1;
        phase_nxt = PH_VAL;
      end else begin
        res[0] = mk_res(fuqp_pkg::KIND_KEY, c, 1'b0, pd_nxt, err_nxt);
        n_res  = 2'd1;
      end
    end

    if (in_ch.is_last) begin
      // escape cut short by end of string
      if (phase_nxt == PH_HEX1 || phase_nxt == PH_HEX2) begin
        err_nxt    = 1'b1;
        phase_nxt  = PH_DROP;
        seg_nxt    = 1'b0;
        eq_nxt     = 1'b0;
        res[n_res] = mk_res(fuqp_pkg::KIND_ERR, 8'd0, 1'b0, pd_nxt, 1'b1);
        n_res      = n_res + 2'd1;
      end
      if (phase_nxt != PH_DROP && seg_nxt) begin
        if (!(&pd_nxt)) pd_nxt = pd_nxt + COUNT_BITS'(1);
        res[n_res] = mk_res(fuqp_pkg::KIND_PAIR, 8'd0, eq_nxt, pd_nxt, err_nxt);
        n_res      = n_res + 2'd1;
      end
      res[n_res] = mk_res(fuqp_pkg::KIND_END, 8'd0, 1'b0, pd_nxt, err_nxt);
      n_res      = n_res + 2'd1;
      phase_nxt  = PH_KEY;
      start_nxt  = 1'b1;
      seg_nxt    = 1'b0;
      eq_nxt     = 1'b0;
      hn_nxt     = 4'd0;
      pd_nxt     = '0;
      err_nxt    = 1'b0;
    end

    if (n_res != 2'd0) res[n_res - 2'd1].last_result = 1'b1;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_fire)  cnt_nxt = cnt_nxt + CNT_BITS'(n_res);
    if (out_fire) cnt_nxt = cnt_nxt - CNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_KEY;
      start_r  <= 1'b1;
      seg_r    <= 1'b0;
      eq_r     <= 1'b0;
      hn_r     <= 4'd0;
      pd_r     <= '0;
      err_r    <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_fire) begin
        phase_r  <= phase_nxt;
        start_r  <= start_nxt;
        seg_r    <= seg_nxt;
        eq_r     <= eq_nxt;
        hn_r     <= hn_nxt;
        pd_r     <= pd_nxt;
        err_r    <= err_nxt;
        wr_ptr_r <= wr_ptr_r + PTR_BITS'(n_res);
      end
      if (out_fire) rd_ptr_r <= rd_ptr_r + PTR_BITS'(1);
      cnt_r <= cnt_nxt;
    end
  end

  // result queue payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < fuqp_pkg::MAX_RES; i++) begin
        if (i < int'(n_res)) fifo_r[wr_ptr_r + PTR_BITS'(i)] <= res[i];
      end
    end
  end

  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.kind        = fifo_r[rd_ptr_r].kind;
  assign out_ch.data        = fifo_r[rd_ptr_r].data;
  assign out_ch.has_value   = fifo_r[rd_ptr_r].has_value;
  assign out_ch.pair_count  = fifo_r[rd_ptr_r].pair_count;
  assign out_ch.error_seen  = fifo_r[rd_ptr_r].error_seen;
  assign out_ch.last_result = fifo_r[rd_ptr_r].last_result;

  // queue never overfills
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_BITS'(fuqp_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // a string end always leaves at least its end result queued
  a_end_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.is_last) |=> (cnt_r != '0))
    else $error("string end produced no result");

  // after a string end the parser is back at string start
  a_end_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.is_last) |=> (start_r && pd_r == '0 && !err_r && !seg_r))
    else $error("parser state not cleared at string end");

  // queue occupancy holds steady when no byte is taken and no result is popped
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_fire && !out_fire) |=> $stable(cnt_r))
    else $error("queue count changed without a beat");

endmodule
